### hdl/gatg_pkg.sv
// ----------------------------------------------------------------------------
// gatg_pkg
// Shared types and constants of the gated alarm tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gatg_pkg;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_WARN_STEP      = 3'd0,
    REG_CAUTION_STEP   = 3'd1,
    REG_WARN_AMP       = 3'd2,
    REG_CAUTION_AMP    = 3'd3,
    REG_WARN_PERIOD    = 3'd4,
    REG_WARN_ON_LEN    = 3'd5,
    REG_CAUTION_PERIOD = 3'd6,
    REG_CAUTION_ON_LEN = 3'd7
  } reg_idx_e;

  typedef enum logic [LEVEL_W-1:0] {
    LEVEL_SILENT  = 2'd0,
    LEVEL_CAUTION = 2'd1,
    LEVEL_WARN    = 2'd2,
    LEVEL_MUTE    = 2'd3
  } level_e;

  typedef struct packed {
    logic [PHASE_W-1:0] warn_step;
    logic [PHASE_W-1:0] caution_step;
    logic [AMP_W-1:0]   warn_amp;
    logic [AMP_W-1:0]   caution_amp;
    logic [CNT_W-1:0]   warn_period;
    logic [CNT_W-1:0]   warn_on_len;
    logic [CNT_W-1:0]   caution_period;
    logic [CNT_W-1:0]   caution_on_len;
  } cfg_t;

  typedef struct packed {
    logic               gate;
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] step;
  } tone_sel_t;

  localparam logic [PHASE_W-1:0] RST_WARN_STEP      = 32'd89600225;
  localparam logic [PHASE_W-1:0] RST_CAUTION_STEP   = 32'd62330591;
  localparam logic [AMP_W-1:0]   RST_WARN_AMP       = 15'd5898;
  localparam logic [AMP_W-1:0]   RST_CAUTION_AMP    = 15'd3932;
  localparam logic [CNT_W-1:0]   RST_WARN_PERIOD    = 16'd10584;
  localparam logic [CNT_W-1:0]   RST_WARN_ON_LEN    = 16'd5292;
  localparam logic [CNT_W-1:0]   RST_CAUTION_PERIOD = 16'd44100;
  localparam logic [CNT_W-1:0]   RST_CAUTION_ON_LEN = 16'd11025;

endpackage

`default_nettype wire

### hdl/gatg_cfg_regs.sv
// ----------------------------------------------------------------------------
// gatg_cfg_regs
// APB register file holding the tone and gate settings.
// ----------------------------------------------------------------------------
`default_nettype none

module gatg_cfg_regs
  import gatg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WARN_STEP:      cfg_d.warn_step      = pwdata;
        REG_CAUTION_STEP:   cfg_d.caution_step   = pwdata;
        REG_WARN_AMP:       cfg_d.warn_amp       = pwdata[AMP_W-1:0];
        REG_CAUTION_AMP:    cfg_d.caution_amp    = pwdata[AMP_W-1:0];
        REG_WARN_PERIOD:    cfg_d.warn_period    = pwdata[CNT_W-1:0];
        REG_WARN_ON_LEN:    cfg_d.warn_on_len    = pwdata[CNT_W-1:0];
        REG_CAUTION_PERIOD: cfg_d.caution_period = pwdata[CNT_W-1:0];
        REG_CAUTION_ON_LEN: cfg_d.caution_on_len = pwdata[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WARN_STEP:      prdata = cfg_q.warn_step;
      REG_CAUTION_STEP:   prdata = cfg_q.caution_step;
      REG_WARN_AMP:       prdata = DATA_W'(cfg_q.warn_amp);
      REG_CAUTION_AMP:    prdata = DATA_W'(cfg_q.caution_amp);
      REG_WARN_PERIOD:    prdata = DATA_W'(cfg_q.warn_period);
      REG_WARN_ON_LEN:    prdata = DATA_W'(cfg_q.warn_on_len);
      REG_CAUTION_PERIOD: prdata = DATA_W'(cfg_q.caution_period);
      REG_CAUTION_ON_LEN: prdata = DATA_W'(cfg_q.caution_on_len);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_step      <= RST_WARN_STEP;
      cfg_q.caution_step   <= RST_CAUTION_STEP;
      cfg_q.warn_amp       <= RST_WARN_AMP;
      cfg_q.caution_amp    <= RST_CAUTION_AMP;
      cfg_q.warn_period    <= RST_WARN_PERIOD;
      cfg_q.warn_on_len    <= RST_WARN_ON_LEN;
      cfg_q.caution_period <= RST_CAUTION_PERIOD;
      cfg_q.caution_on_len <= RST_CAUTION_ON_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hdl/gatg_gate.sv
// ----------------------------------------------------------------------------
// gatg_gate
// Beat-driven gate counters and tone selection by alarm level.
// ----------------------------------------------------------------------------
`default_nettype none

module gatg_gate
  import gatg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire logic [LEVEL_W-1:0] level_i,
  input  wire cfg_t               cfg_i,
  output      tone_sel_t          sel_o
);

  logic [CNT_W-1:0] warn_cnt_q, warn_cnt_d;
  logic [CNT_W-1:0] caution_cnt_q, caution_cnt_d;
  logic [CNT_W:0]   warn_inc, caution_inc;

  assign warn_inc    = {1'b0, warn_cnt_q} + (CNT_W+1)'(1);
  assign caution_inc = {1'b0, caution_cnt_q} + (CNT_W+1)'(1);

  always_comb begin
    warn_cnt_d    = warn_cnt_q;
    caution_cnt_d = caution_cnt_q;
    if (advance_i) begin
      warn_cnt_d    = (warn_inc >= {1'b0, cfg_i.warn_period}) ?
                      '0 : warn_inc[CNT_W-1:0];
      caution_cnt_d = (caution_inc >= {1'b0, cfg_i.caution_period}) ?
                      '0 : caution_inc[CNT_W-1:0];
    end
  end

  always_comb begin
    unique case (level_e'(level_i))
      LEVEL_WARN: begin
        sel_o.gate = warn_cnt_q < cfg_i.warn_on_len;
        sel_o.amp  = cfg_i.warn_amp;
        sel_o.step = cfg_i.warn_step;
      end
      LEVEL_CAUTION: begin
        sel_o.gate = caution_cnt_q < cfg_i.caution_on_len;
        sel_o.amp  = cfg_i.caution_amp;
        sel_o.step = cfg_i.caution_step;
      end
      LEVEL_SILENT, LEVEL_MUTE: begin
        sel_o.gate = 1'b0;
        sel_o.amp  = '0;
        sel_o.step = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_cnt_q    <= '0;
      caution_cnt_q <= '0;
    end else begin
      warn_cnt_q    <= warn_cnt_d;
      caution_cnt_q <= caution_cnt_d;
    end
  end

endmodule

`default_nettype wire

### hdl/gatg_sine.sv
// ----------------------------------------------------------------------------
// gatg_sine
// Phase accumulator, quarter-wave sine table and amplitude scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module gatg_sine
  import gatg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire tone_sel_t        sel_i,
  output      logic [OUT_W-1:0] sample_o,
  output      logic             tone_on_o
);

  localparam int unsigned IW        = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PW        = 30 + IW + 1;
  localparam int unsigned MW        = SAMPLE_WIDTH + AMP_W + 1;
  localparam int unsigned TWO_DEPTH = 2 * SINE_TABLE_DEPTH;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SAMPLE_WIDTH-1:0] rom_t [SINE_TABLE_DEPTH];

  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    return sum;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] full;
    logic [63:0] ang;
    logic [63:0] v;
    full = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      ang = HALF_PI_Q30 * (64'(2 * k) + 64'd1) / TWO_DEPTH;
      v   = (sin_q30(ang) * full + (64'd1 << 29)) >> 30;
      if (v > full) begin
        v = full;
      end
      rom[k] = v[SAMPLE_WIDTH-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [1:0]            quad;
  logic [PW-1:0]         idx_prod;
  logic [IW:0]           idx_hi;
  logic [IW-1:0]         idx_lin, idx;
  logic [SAMPLE_WIDTH-1:0] tab;
  logic [MW-1:0]         scaled;
  logic [OUT_W:0]        mag_wide;
  logic [OUT_W-1:0]      mag;

  assign quad     = phase_q[PHASE_W-1 -: 2];
  assign idx_prod = PW'(phase_q[29:0]) * PW'(SINE_TABLE_DEPTH);
  assign idx_hi   = idx_prod[PW-1:30];
  assign idx_lin  = (idx_hi >= (IW+1)'(SINE_TABLE_DEPTH)) ?
                    IW'(SINE_TABLE_DEPTH - 1) : idx_hi[IW-1:0];
  assign idx      = quad[0] ? (IW'(SINE_TABLE_DEPTH - 1) - idx_lin) : idx_lin;
  assign tab      = SINE_ROM[idx];
  assign scaled   = MW'(tab) * MW'(sel_i.amp) + (MW'(1) << (SAMPLE_WIDTH - 2));
  assign mag_wide = scaled[MW-1:SAMPLE_WIDTH-1];
  assign mag      = (mag_wide > (OUT_W+1)'(32767)) ? OUT_W'(32767) : mag_wide[OUT_W-1:0];

  always_comb begin
    tone_on_o = sel_i.gate;
    sample_o  = '0;
    if (sel_i.gate) begin
      sample_o = quad[1] ? (OUT_W'(0) - mag) : mag;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (advance_i && sel_i.gate) begin
      phase_d = phase_q + sel_i.step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  a_phase_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance_i && sel_i.gate) |=> $stable(phase_q))
    else $error("phase moved without a gated beat");

  a_phase_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && sel_i.gate) |=> phase_q == $past(phase_q) + $past(sel_i.step))
    else $error("phase did not advance by the selected step");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sel_i.gate |-> (sample_o == '0 && !tone_on_o))
    else $error("sample not zero while gated off");

endmodule

`default_nettype wire

### hdl/gated_alarm_tone_generator.sv
// ----------------------------------------------------------------------------
// gated_alarm_tone_generator
// Gated sine alarm tone source: one audio sample for each alarm-level beat.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                 | tuser
//  s_axis   | in        | [1:0] alarm_level     | -
//  m_axis   | out       | [15:0] sample_out     | [0] tone_on
//  apb      | in/out    | 8 registers at 4*i    | -
//
//  Each beat passes through an input register, then gate select, table read
//  and one multiply into the output register.
//  A new beat is taken every cycle unless m_axis stalls; the output register
//  then holds and the input register fills behind it.
//  Reset clears the phase, gate counters and valid flags; settings return to
//  their defaults. The sine table is a constant and needs no fill time.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_alarm_tone_generator
  import gatg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [1:0] alarm_level
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output      logic [15:0]       m_axis_tdata,   // [15:0] sample_out
  output      logic [0:0]        m_axis_tuser,   // [0] tone_on
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  cfg_t               cfg;
  tone_sel_t          sel;
  logic               in_valid_q;
  logic [LEVEL_W-1:0] in_level_q;
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_sample_q;
  logic               out_tone_q;
  logic [OUT_W-1:0]   sample;
  logic               tone_on;
  logic               move;
  logic               in_fire;

  assign move          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_tone_q;

  gatg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gatg_gate u_gate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (move),
    .level_i   (in_level_q),
    .cfg_i     (cfg),
    .sel_o     (sel)
  );

  gatg_sine #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH)
  ) u_sine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (move),
    .sel_i     (sel),
    .sample_o  (sample),
    .tone_on_o (tone_on)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_level_q <= s_axis_tdata[LEVEL_W-1:0];
    end
    if (move) begin
      out_sample_q <= sample;
      out_tone_q   <= tone_on;
    end
  end

endmodule

`default_nettype wire

### verif/tb_gated_alarm_tone_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gated_alarm_tone_generator
// Self-checking bench for the gated alarm tone generator. A directed table
// covers silent levels, zero on-lengths, zero and one-sample periods, a period
// lowered below its counter and the extremes of amplitude and phase step.
// Random phases follow with fresh settings, gaps on each stream chosen at
// random, one with no gaps and a long sink stall. A bit-exact predictor with
// its own sine ROM, phase and gate counters checks every output beat in order.
// ----------------------------------------------------------------------------

module tb_gated_alarm_tone_generator;
  import gatg_pkg::*;

  localparam int          SINE_DEPTH    = 256;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FULL_SCALE  = 64'd32767;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          LONG_STALL    = 80;
  localparam int          PHASES        = 8;
  localparam int          PHASE_BEATS   = 66;
  localparam int          NROWS         = 38;

  typedef enum logic { ROW_BEAT, ROW_CFG } row_kind_e;

  typedef struct {
    logic [15:0] smp;
    logic        tone;
  } tone_beat_t;

  typedef struct {
    row_kind_e   kind;
    reg_idx_e    reg_sel;
    logic [31:0] value;
    level_e      lvl;
    bit          known;
    logic [15:0] smp;
    logic        tone;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;   // [1:0] alarm_level
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;         // [15:0] sample_out
  logic [0:0]        m_axis_tuser;         // [0] tone_on
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [15:0] sine_rom [SINE_DEPTH];
  cfg_t        gen_cfg;
  logic [31:0] phase_acc;
  logic [15:0] warn_cnt;
  logic [15:0] caution_cnt;
  tone_beat_t  tone_q [$];

  int fault_cnt      = 0;
  int cycle_cnt      = 0;
  bit src_gaps       = 1'b1;
  bit sink_gaps      = 1'b1;
  bit long_stall_req = 1'b0;
  int stall_left     = 0;
  int sink_wait      = 0;

  dir_row_t script [NROWS] = '{
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_SILENT,  1'b1, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_MUTE,    1'b1, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_CAUTION, 1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_ON_LEN,    32'd0,          LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b1, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_PERIOD,    32'd0,          LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_ON_LEN,    32'd65535,      LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_AMP,       32'd32767,      LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_STEP,      32'hFFFF_FFFF,  LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_CAUTION_AMP,    32'd0,          LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_CAUTION_ON_LEN, 32'd65535,      LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_CAUTION_PERIOD, 32'd65535,      LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_CAUTION, 1'b1, 16'd0, 1'b1},
    '{ROW_CFG,  REG_CAUTION_AMP,    32'd32767,      LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_CAUTION_STEP,   32'h4000_0000,  LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_CAUTION, 1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_CAUTION, 1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_CAUTION, 1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_CAUTION, 1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_PERIOD,    32'd1,          LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_ON_LEN,    32'd1,          LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_PERIOD,    32'd65535,      LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_SILENT,  1'b1, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_MUTE,    1'b1, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_SILENT,  1'b1, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_MUTE,    1'b1, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_SILENT,  1'b1, 16'd0, 1'b0},
    '{ROW_CFG,  REG_WARN_PERIOD,    32'd3,          LEVEL_SILENT,  1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b1, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_WARN,    1'b0, 16'd0, 1'b0},
    '{ROW_BEAT, REG_WARN_STEP,      32'd0,          LEVEL_CAUTION, 1'b0, 16'd0, 1'b0}
  };

  gated_alarm_tone_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] step_counter(logic [15:0] cnt, logic [15:0] period);
    logic [16:0] nxt;
    nxt = {1'b0, cnt} + 17'd1;
    return (nxt >= {1'b0, period}) ? 16'd0 : nxt[15:0];
  endfunction

  function automatic tone_beat_t next_tone_sample(level_e lvl);
    tone_beat_t      res;
    logic            gate;
    logic [14:0]     amp;
    logic [31:0]     step;
    logic [1:0]      quad;
    logic [7:0]      idx;
    longint unsigned mag;
    gate = 1'b0;
    amp  = '0;
    step = '0;
    case (lvl)
      LEVEL_WARN: begin
        gate = warn_cnt < gen_cfg.warn_on_len;
        amp  = gen_cfg.warn_amp;
        step = gen_cfg.warn_step;
      end
      LEVEL_CAUTION: begin
        gate = caution_cnt < gen_cfg.caution_on_len;
        amp  = gen_cfg.caution_amp;
        step = gen_cfg.caution_step;
      end
      default: ;
    endcase
    res.smp  = '0;
    res.tone = gate;
    if (gate) begin
      quad = phase_acc[31:30];
      idx  = phase_acc[29:22];
      if (quad[0]) idx = 8'(SINE_DEPTH - 1) - idx;
      mag = (longint'(sine_rom[idx]) * longint'(amp) + 64'd16384) >> 15;
      if (mag > FULL_SCALE) mag = FULL_SCALE;
      res.smp   = quad[1] ? 16'h0 - mag[15:0] : mag[15:0];
      phase_acc = phase_acc + step;
    end
    warn_cnt    = step_counter(warn_cnt, gen_cfg.warn_period);
    caution_cnt = step_counter(caution_cnt, gen_cfg.caution_period);
    return res;
  endfunction

  function automatic level_e pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return LEVEL_SILENT;
    if (r == 1) return LEVEL_MUTE;
    if (r < 6) return LEVEL_CAUTION;
    return LEVEL_WARN;
  endfunction

  function automatic logic [31:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_amp();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd32767;
    return $urandom_range(1, 32766);
  endfunction

  function automatic logic [31:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd65535;
    return $urandom_range(1, 24);
  endfunction

  function automatic logic [31:0] pick_on_len(logic [31:0] period);
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(0, 7);
    top = (period >= 32'd65535) ? 65535 : period + 1;
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd65535;
    return $urandom_range(0, top);
  endfunction

  // write one register, then read it back
  task automatic program_reg(reg_idx_e sel, logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    mask = 32'h0000_FFFF;
    case (sel)
      REG_WARN_STEP: begin
        gen_cfg.warn_step = val;
        mask = 32'hFFFF_FFFF;
      end
      REG_CAUTION_STEP: begin
        gen_cfg.caution_step = val;
        mask = 32'hFFFF_FFFF;
      end
      REG_WARN_AMP: begin
        gen_cfg.warn_amp = val[14:0];
        mask = 32'h0000_7FFF;
      end
      REG_CAUTION_AMP: begin
        gen_cfg.caution_amp = val[14:0];
        mask = 32'h0000_7FFF;
      end
      REG_WARN_PERIOD:    gen_cfg.warn_period    = val[15:0];
      REG_WARN_ON_LEN:    gen_cfg.warn_on_len    = val[15:0];
      REG_CAUTION_PERIOD: gen_cfg.caution_period = val[15:0];
      REG_CAUTION_ON_LEN: gen_cfg.caution_on_len = val[15:0];
      default: ;
    endcase
    if (got !== (val & mask)) begin
      fault_cnt++;
      $display("%0t: readback %s expected %h actual %h", $time, sel.name(),
               val & mask, got);
    end
  endtask

  // offer one beat; returns at the falling edge after acceptance
  task automatic send_beat(level_e lvl, bit known, logic [15:0] smp, logic tone);
    int         gap;
    tone_beat_t pred;
    gap = src_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = next_tone_sample(lvl);
    if (known) begin
      pred.smp  = smp;
      pred.tone = tone;
    end
    tone_q.push_back(pred);
    @(negedge clk_i);
  endtask

  // drop valid and hold until every pending sample has come out
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (tone_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : sink
    forever begin
      @(negedge clk_i);
      m_axis_tready <= (stall_left == 0) && (sink_wait == 0);
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end else if (m_axis_tvalid && m_axis_tready) begin
        sink_wait = sink_gaps ? $urandom_range(0, 16) : 0;
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
    end
  end

  always @(posedge clk_i) begin
    tone_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tone_q.size() == 0) begin
        fault_cnt++;
        $display("%0t: sample beat expected none actual %h tone_on %b", $time,
                 m_axis_tdata, m_axis_tuser[0]);
      end else begin
        want = tone_q.pop_front();
        if (m_axis_tdata !== want.smp) begin
          fault_cnt++;
          $display("%0t: sample_out expected %h actual %h", $time, want.smp,
                   m_axis_tdata);
        end
        if (m_axis_tuser[0] !== want.tone) begin
          fault_cnt++;
          $display("%0t: tone_on expected %b actual %b", $time, want.tone,
                   m_axis_tuser[0]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    longint unsigned ang;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned v;
    logic [31:0]     per;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      ang  = HALF_PI_Q30 * longint'(2 * k + 1) / longint'(2 * SINE_DEPTH);
      x2   = (ang * ang) >> 30;
      term = ang;
      acc  = ang;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'(2 * n * (2 * n + 1));
        if (n % 2 == 1) acc = (acc >= term) ? acc - term : 64'd0;
        else acc = acc + term;
      end
      v = (acc * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) v = FULL_SCALE;
      sine_rom[k] = v[15:0];
    end
    gen_cfg = '{RST_WARN_STEP, RST_CAUTION_STEP, RST_WARN_AMP, RST_CAUTION_AMP,
                RST_WARN_PERIOD, RST_WARN_ON_LEN, RST_CAUTION_PERIOD,
                RST_CAUTION_ON_LEN};
    phase_acc   = '0;
    warn_cnt    = '0;
    caution_cnt = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NROWS; r++) begin
      if (script[r].kind == ROW_CFG) begin
        settle_idle();
        program_reg(script[r].reg_sel, script[r].value);
      end else begin
        send_beat(script[r].lvl, script[r].known, script[r].smp, script[r].tone);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      program_reg(REG_WARN_STEP, pick_step());
      program_reg(REG_CAUTION_STEP, pick_step());
      program_reg(REG_WARN_AMP, pick_amp());
      program_reg(REG_CAUTION_AMP, pick_amp());
      per = pick_period();
      program_reg(REG_WARN_PERIOD, per);
      program_reg(REG_WARN_ON_LEN, pick_on_len(per));
      per = pick_period();
      program_reg(REG_CAUTION_PERIOD, per);
      program_reg(REG_CAUTION_ON_LEN, pick_on_len(per));
      src_gaps  = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_gaps = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p == 3 && n == 5) long_stall_req = 1'b1;
        if (p == 5 && n == 30) settle_idle();
        send_beat(pick_level(), 1'b0, 16'd0, 1'b0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (tone_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
